/* hw/rtl/vpv_pkg.sv */
`timescale 1ns / 1ps

package vpv_pkg;

    localparam int MAX_PATH = 256;
    localparam int CNT_W    = $clog2(MAX_PATH + 1);
    localparam int CAP_W    = 9;
    localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_RANGE   = 2'd2;

    localparam logic [1:0] PH_VOLUME = 2'd0;
    localparam logic [1:0] PH_SLASH  = 2'd1;
    localparam logic [1:0] PH_COMP   = 2'd2;

    localparam logic [4:0] VOL_SAT = 5'd16;

    localparam logic [1:0] CLASS_TWO   = 2'd1;
    localparam logic [1:0] CLASS_THREE = 2'd2;
    localparam logic [1:0] CLASS_FOUR  = 2'd3;

    typedef struct packed {
        logic [7:0] path_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] canonical_length;
    } out_item_t;

    typedef struct packed {
        logic [CNT_W-1:0] byte_count;
        logic [4:0]       volume_length;
        logic [1:0]       parse_phase;
        logic [1:0]       component_length;
        logic             component_all_dots;
        logic [1:0]       utf8_pending;
        logic [20:0]      utf8_value;
        logic [1:0]       utf8_min_class;
        logic             error_seen;
    } path_state_t;

    function automatic path_state_t path_reset();
        path_state_t s;
        s.byte_count         = '0;
        s.volume_length      = '0;
        s.parse_phase        = PH_VOLUME;
        s.component_length   = '0;
        s.component_all_dots = 1'b1;
        s.utf8_pending       = '0;
        s.utf8_value         = '0;
        s.utf8_min_class     = '0;
        s.error_seen         = 1'b0;
        return s;
    endfunction

endpackage

/* hw/rtl/vpv_step.sv */
`timescale 1ns / 1ps

module vpv_step
    import vpv_pkg::*;
(
    input  path_state_t      state,
    input  in_item_t         item,
    input  logic [CAP_W-1:0] capacity_limit,
    output path_state_t      state_next,
    output out_item_t        verdict
);

    logic [7:0]       c;
    logic             is_slash;
    logic             vol_char;
    logic             forbidden;
    logic             drop_slash;
    logic             cont_ok;
    logic [20:0]      shifted;
    logic [20:0]      minimum;
    logic             cp_bad;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] length;
    logic             out_of_range;
    path_state_t      s;

    assign c        = item.path_byte;
    assign is_slash = (c == 8'h2F);
    assign vol_char = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h30 && c <= 8'h39)
                      || (c == 8'h2D);
    // Control characters, DEL and \ : * ? " < > |
    assign forbidden = (c < 8'h20) || (c == 8'h7F) || (c == 8'h5C) || (c == 8'h3A)
                       || (c == 8'h2A) || (c == 8'h3F) || (c == 8'h22) || (c == 8'h3C)
                       || (c == 8'h3E) || (c == 8'h7C);
    assign cont_ok  = (c[7:6] == 2'b10);
    assign shifted  = {state.utf8_value[14:0], c[5:0]};
    assign minimum  = (state.utf8_min_class == CLASS_TWO)   ? 21'h80 :
                      (state.utf8_min_class == CLASS_THREE) ? 21'h800 : 21'h10000;
    assign cp_bad   = (shifted < minimum) || (shifted > 21'h10FFFF)
                      || (shifted >= 21'hD800 && shifted <= 21'hDFFF);

    always_comb
    begin
        s          = state;
        drop_slash = 1'b0;
        if (state.byte_count < CNT_W'(MAX_PATH))
        begin
            s.byte_count = state.byte_count + CNT_W'(1);
        end

        case (state.parse_phase)
            PH_VOLUME:
            begin
                if (c == 8'h3A)
                begin
                    if (state.volume_length == 5'd0 || state.volume_length >= VOL_SAT)
                    begin
                        s.error_seen = 1'b1;
                    end
                    s.parse_phase = PH_SLASH;
                end
                else
                begin
                    if (!vol_char)
                    begin
                        s.error_seen = 1'b1;
                    end
                    if (state.volume_length < VOL_SAT)
                    begin
                        s.volume_length = state.volume_length + 5'd1;
                    end
                end
                if (item.last_byte)
                begin
                    s.error_seen = 1'b1;
                end
            end
            PH_SLASH:
            begin
                if (!is_slash)
                begin
                    s.error_seen = 1'b1;
                end
                s.parse_phase = PH_COMP;
            end
            PH_COMP:
            begin
                if (is_slash)
                begin
                    if (state.utf8_pending != 2'd0 || state.component_length == 2'd0
                        || ((state.component_length == 2'd1 || state.component_length == 2'd2)
                            && state.component_all_dots))
                    begin
                        s.error_seen = 1'b1;
                    end
                    s.component_length   = '0;
                    s.component_all_dots = 1'b1;
                    s.utf8_pending       = '0;
                    s.utf8_value         = '0;
                    s.utf8_min_class     = '0;
                    drop_slash           = item.last_byte;
                end
                else
                begin
                    if (state.component_length != 2'd3)
                    begin
                        s.component_length = state.component_length + 2'd1;
                    end
                    if (c != 8'h2E)
                    begin
                        s.component_all_dots = 1'b0;
                    end
                    if (state.utf8_pending != 2'd0)
                    begin
                        if (!cont_ok)
                        begin
                            s.error_seen   = 1'b1;
                            s.utf8_pending = '0;
                        end
                        else
                        begin
                            s.utf8_value   = shifted;
                            s.utf8_pending = state.utf8_pending - 2'd1;
                            if (state.utf8_pending == 2'd1 && cp_bad)
                            begin
                                s.error_seen = 1'b1;
                            end
                        end
                    end
                    else if (c < 8'h80)
                    begin
                        if (forbidden)
                        begin
                            s.error_seen = 1'b1;
                        end
                    end
                    else if (c >= 8'hC2 && c <= 8'hDF)
                    begin
                        s.utf8_pending   = 2'd1;
                        s.utf8_value     = {16'd0, c[4:0]};
                        s.utf8_min_class = CLASS_TWO;
                    end
                    else if (c >= 8'hE0 && c <= 8'hEF)
                    begin
                        s.utf8_pending   = 2'd2;
                        s.utf8_value     = {17'd0, c[3:0]};
                        s.utf8_min_class = CLASS_THREE;
                    end
                    else if (c >= 8'hF0 && c <= 8'hF4)
                    begin
                        s.utf8_pending   = 2'd3;
                        s.utf8_value     = {18'd0, c[2:0]};
                        s.utf8_min_class = CLASS_FOUR;
                    end
                    else
                    begin
                        s.error_seen = 1'b1;
                    end
                    // The last byte closes the final component.
                    if (item.last_byte)
                    begin
                        if (s.utf8_pending != 2'd0
                            || ((s.component_length == 2'd1 || s.component_length == 2'd2)
                                && s.component_all_dots))
                        begin
                            s.error_seen = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                s.error_seen = 1'b1;
            end
        endcase
    end

    assign count        = s.byte_count;
    assign length       = drop_slash ? (count - CNT_W'(1)) : count;
    assign out_of_range = (count >= CNT_W'(MAX_PATH))
                          || (CMP_W'(count) >= CMP_W'(capacity_limit));

    always_comb
    begin
        if (out_of_range)
        begin
            verdict.status           = STATUS_RANGE;
            verdict.canonical_length = '0;
        end
        else if (s.error_seen)
        begin
            verdict.status           = STATUS_INVALID;
            verdict.canonical_length = '0;
        end
        else
        begin
            verdict.status           = STATUS_OK;
            verdict.canonical_length = length[7:0];
        end
    end

    assign state_next = item.last_byte ? path_reset() : s;

endmodule

/* hw/rtl/volume_path_validator.sv */
// out_valid rises when a path's last byte leaves the input register and its verdict loads the output register.
// Throughput: one byte per cycle, sustained under no output stall.
// A byte sits in the input register, then one pass of parser logic updates the path
// state and, on the last byte, loads the output register.
// Reset clears the path state and both valid flags; capacity_limit returns to 256.
`timescale 1ns / 1ps

module volume_path_validator
    import vpv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data
);

    logic             in_valid_reg;
    in_item_t         in_item_reg;
    logic             out_valid_reg;
    out_item_t        out_item_reg;
    logic [CAP_W-1:0] cap_reg;
    path_state_t      state_reg;
    path_state_t      state_next;
    out_item_t        verdict;
    logic             advance;
    logic             out_free;

    assign out_free = !out_valid_reg || out_ready;
    // A byte that carries no verdict never waits for the output side.
    assign advance  = in_valid_reg && (!in_item_reg.last_byte || out_free);
    assign in_ready = !in_valid_reg || advance;

    vpv_step u_step (
        .state          (state_reg),
        .item           (in_item_reg),
        .capacity_limit (cap_reg),
        .state_next     (state_next),
        .verdict        (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cap_reg       <= CAP_RESET;
            state_reg     <= path_reset();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance && in_item_reg.last_byte)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg <= in_data;
        end
        if (advance && in_item_reg.last_byte)
        begin
            out_item_reg <= verdict;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

`ifndef SYNTH
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_item_reg.last_byte |=>
            state_reg.parse_phase == PH_VOLUME && state_reg.byte_count == '0)
        else $error("path state not cleared after the last byte");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.byte_count <= CNT_W'(MAX_PATH))
        else $error("byte count beyond the path limit");

    a_zero_len_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.status != STATUS_OK |->
            out_item_reg.canonical_length == 8'd0)
        else $error("failed verdict carries a length");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_item_reg.status == STATUS_OK
            || out_item_reg.status == STATUS_INVALID || out_item_reg.status == STATUS_RANGE)
        else $error("undefined status code");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !(advance && in_item_reg.last_byte))
        else $error("pending verdict overwritten");
`endif

endmodule

/* verif/tb_volume_path_validator.sv */
`timescale 1ns / 1ps

module tb_volume_path_validator;
    import vpv_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_BYTES  = 45;
    localparam int N_CAP_PLAN   = 8;
    localparam logic [CAP_W-1:0] CAP_PLAN [0:N_CAP_PLAN-1] =
        '{9'd0, 9'd1, 9'd3, 9'd4, 9'd12, 9'd511, 9'd40, 9'd256};

    typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_HOLD} rx_mode_e;

    // Predicts one verdict per path from the bytes as they are accepted.
    class path_scoreboard;
        logic [CAP_W-1:0] capacity;
        logic [CNT_W-1:0] byte_count;
        logic [4:0]       vol_len;
        logic [1:0]       phase;
        logic [1:0]       comp_len;
        bit               all_dots;
        logic [1:0]       pending;
        logic [20:0]      code_point;
        logic [1:0]       seq_class;
        bit               bad;
        out_item_t        verdicts[$];
        int               mismatches;

        function new();
            capacity   = CAP_RESET;
            mismatches = 0;
            clear_path();
        endfunction

        function void set_capacity(logic [CAP_W-1:0] v);
            capacity = v;
        endfunction

        function int outstanding();
            return verdicts.size();
        endfunction

        function void clear_path();
            byte_count = '0;
            vol_len    = '0;
            phase      = PH_VOLUME;
            comp_len   = '0;
            all_dots   = 1'b1;
            pending    = '0;
            code_point = '0;
            seq_class  = '0;
            bad        = 1'b0;
        endfunction

        function void end_component(bit at_slash);
            if (pending != 0)
                bad = 1'b1;
            if (at_slash && comp_len == 0)
                bad = 1'b1;
            if ((comp_len == 1 || comp_len == 2) && all_dots)
                bad = 1'b1;
            comp_len   = '0;
            all_dots   = 1'b1;
            pending    = '0;
            code_point = '0;
            seq_class  = '0;
        endfunction

        function void component_byte(logic [7:0] c);
            logic [20:0] floor_cp;
            if (comp_len < 3)
                comp_len++;
            if (c != ".")
                all_dots = 1'b0;
            if (pending != 0)
            begin
                if (c[7:6] != 2'b10)
                begin
                    bad     = 1'b1;
                    pending = '0;
                    return;
                end
                code_point = {code_point[14:0], c[5:0]};
                pending--;
                if (pending == 0)
                begin
                    floor_cp = (seq_class == CLASS_TWO)   ? 21'h80 :
                               (seq_class == CLASS_THREE) ? 21'h800 : 21'h10000;
                    if (code_point < floor_cp || code_point > 21'h10FFFF ||
                        (code_point >= 21'hD800 && code_point <= 21'hDFFF))
                        bad = 1'b1;
                end
                return;
            end
            if (c < 8'h80)
            begin
                if (c < 8'h20 || c == 8'h7F || c == "\\" || c == ":" || c == "*" ||
                    c == "?" || c == "\"" || c == "<" || c == ">" || c == "|")
                    bad = 1'b1;
            end
            else if (c >= 8'hC2 && c <= 8'hDF)
            begin
                pending    = 2'd1;
                code_point = {16'd0, c[4:0]};
                seq_class  = CLASS_TWO;
            end
            else if (c >= 8'hE0 && c <= 8'hEF)
            begin
                pending    = 2'd2;
                code_point = {17'd0, c[3:0]};
                seq_class  = CLASS_THREE;
            end
            else if (c >= 8'hF0 && c <= 8'hF4)
            begin
                pending    = 2'd3;
                code_point = {18'd0, c[2:0]};
                seq_class  = CLASS_FOUR;
            end
            else
                bad = 1'b1;
        endfunction

        function void note_byte(in_item_t item);
            logic [7:0] c;
            bit         drop_slash;
            out_item_t  v;
            c          = item.path_byte;
            drop_slash = 1'b0;
            if (byte_count < MAX_PATH)
                byte_count++;
            case (phase)
                PH_VOLUME:
                begin
                    if (c == ":")
                    begin
                        if (vol_len == 0 || vol_len >= VOL_SAT)
                            bad = 1'b1;
                        phase = PH_SLASH;
                    end
                    else
                    begin
                        if (!((c >= "a" && c <= "z") || (c >= "0" && c <= "9") || c == "-"))
                            bad = 1'b1;
                        if (vol_len < VOL_SAT)
                            vol_len++;
                    end
                    if (item.last_byte)
                        bad = 1'b1;
                end
                PH_SLASH:
                begin
                    if (c != "/")
                        bad = 1'b1;
                    phase = PH_COMP;
                end
                PH_COMP:
                begin
                    if (c == "/")
                    begin
                        end_component(1'b1);
                        drop_slash = item.last_byte;
                    end
                    else
                    begin
                        component_byte(c);
                        if (item.last_byte)
                            end_component(1'b0);
                    end
                end
                default:
                    bad = 1'b1;
            endcase
            if (!item.last_byte)
                return;
            v.canonical_length = '0;
            if (byte_count >= MAX_PATH || byte_count >= capacity)
                v.status = STATUS_RANGE;
            else if (bad)
                v.status = STATUS_INVALID;
            else
            begin
                v.status           = STATUS_OK;
                v.canonical_length = 8'(drop_slash ? byte_count - 1 : byte_count);
            end
            verdicts.push_back(v);
            clear_path();
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (verdicts.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected verdict, status %0d length %0d",
                         $time, got.status, got.canonical_length);
                return;
            end
            want = verdicts.pop_front();
            if (got.status !== want.status)
            begin
                mismatches++;
                $display("%0t: status expected %0d, actual %0d",
                         $time, want.status, got.status);
            end
            if (got.canonical_length !== want.canonical_length)
            begin
                mismatches++;
                $display("%0t: canonical_length expected %0d, actual %0d",
                         $time, want.canonical_length, got.canonical_length);
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    in_item_t         in_data = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    out_item_t        out_data;
    logic             cfg_wr_en = 1'b0;
    logic [CAP_W-1:0] cfg_wr_data = '0;

    path_scoreboard sb;
    rx_mode_e       rx_mode = RX_RANDOM;
    bit             hold_done = 1'b0;
    bit             tx_steady = 1'b0;
    int             burst_left = 0;
    int             bytes_sent = 0;
    int             cycle_count = 0;
    logic [7:0]     path_buf[$];

    string volume_chars = "abcdefghijklmnopqrstuvwxyz0123456789-";
    string plain_chars  = "abcdefgXYZ0189 _-+=~!#$%&'()[]{}@,;^";

    volume_path_validator u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_volume_path_validator: errors");
            $finish;
        end
    end

    // Receiver: checks each output transfer and drives out_ready for the next edge.
    initial
    begin
        int run_left;
        bit run_level;
        int hold_count;
        run_left   = 0;
        run_level  = 1'b1;
        hold_count = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_result(out_data);
            if (rx_mode == RX_HOLD && !hold_done)
            begin
                out_ready <= 1'b0;
                hold_count++;
                if (hold_count >= HOLD_CYCLES)
                    hold_done = 1'b1;
            end
            else if (rx_mode == RX_FREE)
                out_ready <= 1'b1;
            else
            begin
                if (run_left == 0)
                begin
                    run_left  = $urandom_range(1, 8);
                    run_level = ($urandom_range(0, 2) != 0);
                end
                run_left--;
                out_ready <= run_level;
            end
        end
    end

    function automatic void add_str(string s);
        for (int k = 0; k < s.len(); k++)
            path_buf.push_back(s[k]);
    endfunction

    // Mostly well-formed paths with random content; some are broken on purpose
    // and some are raw noise.
    function automatic void build_random_path();
        int          kind;
        int          n;
        int          ncomp;
        int          pos;
        logic [20:0] cp;
        path_buf.delete();
        kind = $urandom_range(0, 9);
        if (kind == 9)
        begin
            n = $urandom_range(1, 12);
            repeat (n)
                path_buf.push_back(8'($urandom_range(0, 255)));
            return;
        end
        n = $urandom_range(1, 15);
        repeat (n)
            path_buf.push_back(volume_chars[$urandom_range(0, volume_chars.len() - 1)]);
        add_str(":/");
        ncomp = $urandom_range(0, 4);
        for (int k = 0; k < ncomp; k++)
        begin
            if (k != 0)
                path_buf.push_back("/");
            case ($urandom_range(0, 15))
                0: add_str(".");
                1: add_str("..");
                2: add_str("...");
                3:
                begin
                    n = $urandom_range(20, 90);
                    repeat (n)
                        path_buf.push_back(volume_chars[$urandom_range(0, 25)]);
                end
                default:
                begin
                    n = $urandom_range(1, 5);
                    repeat (n)
                    begin
                        case ($urandom_range(0, 4))
                            0: cp = $urandom_range(21'h80, 21'h7FF);
                            1:
                            begin
                                cp = $urandom_range(21'h800, 21'hFFFF);
                                if (cp >= 21'hD800 && cp <= 21'hDFFF)
                                    cp ^= 21'h1000;
                            end
                            2: cp = $urandom_range(21'h10000, 21'h10FFFF);
                            default: cp = plain_chars[$urandom_range(0, plain_chars.len() - 1)];
                        endcase
                        if (cp < 21'h80)
                            path_buf.push_back(cp[7:0]);
                        else if (cp < 21'h800)
                        begin
                            path_buf.push_back({3'b110, cp[10:6]});
                            path_buf.push_back({2'b10, cp[5:0]});
                        end
                        else if (cp < 21'h10000)
                        begin
                            path_buf.push_back({4'b1110, cp[15:12]});
                            path_buf.push_back({2'b10, cp[11:6]});
                            path_buf.push_back({2'b10, cp[5:0]});
                        end
                        else
                        begin
                            path_buf.push_back({5'b11110, cp[20:18]});
                            path_buf.push_back({2'b10, cp[17:12]});
                            path_buf.push_back({2'b10, cp[11:6]});
                            path_buf.push_back({2'b10, cp[5:0]});
                        end
                    end
                end
            endcase
        end
        if (ncomp > 0 && $urandom_range(0, 3) == 0)
            path_buf.push_back("/");
        if (kind >= 7)
        begin
            pos = $urandom_range(0, path_buf.size() - 1);
            case ($urandom_range(0, 2))
                0: path_buf[pos] = 8'($urandom_range(0, 255));
                1: while (path_buf.size() > pos + 1) void'(path_buf.pop_back());
                default: path_buf.insert(pos, 8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    // Offers one byte; the sender works in bursts with random gaps between them unless tx_steady is set.
    task automatic send_byte(in_item_t item);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (tx_steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_byte(item);
        bytes_sent++;
    endtask

    task automatic send_path();
        in_item_t item;
        for (int k = 0; k < path_buf.size(); k++)
        begin
            item.path_byte = path_buf[k];
            item.last_byte = (k == path_buf.size() - 1);
            send_byte(item);
        end
    endtask

    // Sends head followed by the first n bytes of tail, most significant first.
    task automatic send_bytes(string head, logic [31:0] tail, int n);
        path_buf.delete();
        add_str(head);
        for (int k = 0; k < n; k++)
            path_buf.push_back(tail[31 - 8 * k -: 8]);
        send_path();
    endtask

    task automatic send_long(int n, bit trailing_slash);
        path_buf.delete();
        add_str("a:/");
        repeat (n - 3 - trailing_slash)
            path_buf.push_back("x");
        if (trailing_slash)
            path_buf.push_back("/");
        send_path();
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_capacity(v);
    endtask

    initial
    begin
        int               phase_start;
        logic [CAP_W-1:0] cap;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed paths under the reset capacity.
        send_bytes("a:/", 0, 0);
        send_bytes("ab-9:/x/", 0, 0);
        send_bytes("a", 0, 0);
        send_bytes("a:", 0, 0);
        send_bytes(":/x", 0, 0);
        send_bytes("abcdefghijklmno:/z", 0, 0);
        send_bytes("abcdefghijklmnop:/z", 0, 0);
        send_bytes("A:/x", 0, 0);
        send_bytes("a:x", 0, 0);
        send_bytes("a:/b//c", 0, 0);
        send_bytes("a:/./b", 0, 0);
        send_bytes("a:/..", 0, 0);
        send_bytes("a:/.../.x", 0, 0);
        send_bytes("a:/x<y", 0, 0);
        send_bytes("a:/q\\|", 0, 0);
        send_bytes("a:/", 32'h1F00_0000, 1);
        send_bytes("a:/", 32'h7F00_0000, 1);
        send_bytes("u:/", 32'hC280_0000, 2);
        send_bytes("u:/", 32'hC180_0000, 2);
        send_bytes("u:/", 32'hE09F_BF00, 3);
        send_bytes("u:/", 32'hE0A0_8000, 3);
        send_bytes("u:/", 32'hEDA0_8000, 3);
        send_bytes("u:/", 32'hF090_8080, 4);
        send_bytes("u:/", 32'hF08F_BFBF, 4);
        send_bytes("u:/", 32'hF490_8080, 4);
        send_bytes("u:/", 32'hC200_0000, 1);
        send_bytes("u:/", 32'hC22F_0000, 2);
        send_bytes("u:/", 32'hC241_0000, 2);
        send_bytes("u:/", 32'hFF80_0000, 2);
        wait_idle();

        // The receiver holds off while the sender keeps offering, so the block backs up.
        rx_mode   <= RX_HOLD;
        tx_steady = 1'b1;
        repeat (4)
        begin
            build_random_path();
            send_path();
        end
        while (!hold_done)
            @(posedge clk);
        rx_mode   <= RX_RANDOM;
        tx_steady = 1'b0;
        wait_idle();

        for (int p = 0; p <= N_CAP_PLAN; p++)
        begin
            cap = (p < N_CAP_PLAN) ? CAP_PLAN[p] : CAP_W'($urandom_range(0, 511));
            write_capacity(cap);
            rx_mode   <= (p % 2 == 1) ? RX_FREE : RX_RANDOM;
            tx_steady = (p % 2 == 1);
            phase_start = bytes_sent;
            // Paths at the length limit; the full set only once, at the reset capacity.
            if (p < N_CAP_PLAN && cap >= CAP_W'(MAX_PATH))
            begin
                send_long(MAX_PATH, 1'b0);
                if (cap == CAP_W'(MAX_PATH))
                begin
                    send_long(MAX_PATH - 1, 1'b0);
                    send_long(MAX_PATH - 1, 1'b1);
                end
            end
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                build_random_path();
                send_path();
            end
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("tb_volume_path_validator: clean");
        else
            $display("tb_volume_path_validator: errors");
        $finish;
    end

endmodule
